FILE: rtl/core/line_rasterizer_core_defines.svh
// Assertion helpers for the checker file, lr_checker.sv.
`ifndef LINE_RASTERIZER_CORE_DEFINES_SVH
`define LINE_RASTERIZER_CORE_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define LR_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("line rasterizer check failed");

// Next-cycle implication, checked out of reset.
`define LR_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("line rasterizer check failed");

`endif

FILE: rtl/core/lr_pkg.sv
`timescale 1ns / 1ps

package lr_pkg;

  localparam int COORD_BITS = 12;
  localparam int ERR_BITS   = COORD_BITS + 2;
  localparam int COLOR_BITS = 4;

  localparam logic [COLOR_BITS-1:0] DRAW_COLOR_RESET = 4'hF;

  // APB map: one register at byte address 0, 3-bit address so writes past it are seen
  localparam int APB_ADDR_BITS = 3;
  localparam int APB_DATA_BITS = 32;
  localparam logic REG_DRAW_COLOR = 1'b0;   // register index, paddr[2]

  // command codes on the func field
  localparam logic FUNC_START = 1'b0;
  localparam logic FUNC_STEP  = 1'b1;

  localparam int QUEUE_DEPTH    = 2;
  localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CNT_BITS = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic                  func;
    logic [COORD_BITS-1:0] x_start;
    logic [COORD_BITS-1:0] y_start;
    logic [COORD_BITS-1:0] x_end;
    logic [COORD_BITS-1:0] y_end;
  } in_item_t;

  typedef struct packed {
    logic [COORD_BITS-1:0] pixel_x;
    logic [COORD_BITS-1:0] pixel_y;
    logic [COLOR_BITS-1:0] pixel_color;
    logic                  last_pixel;
  } pixel_t;

  // decoded command handed from front to back
  typedef struct packed {
    logic                  is_start;
    logic [COORD_BITS-1:0] x1;
    logic [COORD_BITS-1:0] y1;
    logic [COORD_BITS-1:0] x2;
    logic [COORD_BITS-1:0] y2;
    logic [COORD_BITS-1:0] abs_dx;
    logic [COORD_BITS-1:0] abs_dy;
    logic                  x_neg;
    logic                  y_neg;
  } cmd_t;

endpackage

FILE: rtl/core/lr_front.sv
`timescale 1ns / 1ps

// Classifies incoming transfers and precomputes line setup for starts.
module lr_front (
  input  logic             in_valid_i,
  input  lr_pkg::in_item_t in_data_i,
  input  logic             q_full_i,
  output logic             in_stall_o,
  output logic             push_o,
  output lr_pkg::cmd_t     cmd_o
);

  lr_pkg::in_item_t it;

  assign it         = in_data_i;
  assign in_stall_o = q_full_i;
  assign push_o     = in_valid_i && !q_full_i;

  always_comb begin
    cmd_o          = '0;
    cmd_o.is_start = (it.func == lr_pkg::FUNC_START);
    cmd_o.x1       = it.x_start;
    cmd_o.y1       = it.y_start;
    cmd_o.x2       = it.x_end;
    cmd_o.y2       = it.y_end;
    cmd_o.abs_dx   = (it.x_end >= it.x_start) ? it.x_end - it.x_start
                                              : it.x_start - it.x_end;
    cmd_o.abs_dy   = (it.y_end >= it.y_start) ? it.y_end - it.y_start
                                              : it.y_start - it.y_end;
    cmd_o.x_neg    = (it.x_start >= it.x_end);
    cmd_o.y_neg    = (it.y_start >= it.y_end);
  end

endmodule

FILE: rtl/core/lr_queue.sv
`timescale 1ns / 1ps

// Small command FIFO between front and back.
module lr_queue (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  input  lr_pkg::cmd_t push_cmd_i,
  input  logic         pop_i,
  output logic         full_o,
  output logic         valid_o,
  output lr_pkg::cmd_t head_o
);

  lr_pkg::cmd_t                        entries_q [lr_pkg::QUEUE_DEPTH];
  logic [lr_pkg::QUEUE_PTR_BITS-1:0]   wr_ptr_q, wr_ptr_d;
  logic [lr_pkg::QUEUE_PTR_BITS-1:0]   rd_ptr_q, rd_ptr_d;
  logic [lr_pkg::QUEUE_CNT_BITS-1:0]   count_q, count_d;

  localparam logic [lr_pkg::QUEUE_PTR_BITS-1:0] LastPtr =
    lr_pkg::QUEUE_PTR_BITS'(lr_pkg::QUEUE_DEPTH - 1);

  assign full_o  = (count_q == lr_pkg::QUEUE_CNT_BITS'(lr_pkg::QUEUE_DEPTH));
  assign valid_o = (count_q != '0);
  assign head_o  = entries_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entries_q[wr_ptr_q] <= push_cmd_i;
    end
  end

endmodule

FILE: rtl/core/lr_back.sv
`timescale 1ns / 1ps

// Bresenham stepper with the pixel output register.
module lr_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          q_valid_i,
  input  lr_pkg::cmd_t                  cmd_i,
  input  logic [lr_pkg::COLOR_BITS-1:0] draw_color_i,
  input  logic                          out_stall_i,
  output logic                          pop_o,
  output logic                          out_valid_o,
  output lr_pkg::pixel_t                out_data_o
);

  localparam int WideBits = lr_pkg::ERR_BITS + 1;

  logic [lr_pkg::COORD_BITS-1:0] cur_x_q, cur_x_d, cur_y_q, cur_y_d;
  logic [lr_pkg::COORD_BITS-1:0] tgt_x_q, tgt_x_d, tgt_y_q, tgt_y_d;
  logic [lr_pkg::COORD_BITS-1:0] dx_q, dx_d, dy_q, dy_d;
  logic                          x_neg_q, x_neg_d, y_neg_q, y_neg_d;
  logic signed [lr_pkg::ERR_BITS-1:0] err_q, err_d;
  logic                          active_q, active_d;
  logic                          out_valid_q, out_valid_d;
  lr_pkg::pixel_t                out_data_q, out_data_d;

  logic signed [WideBits-1:0] e2, dx_w, dy_w, err_w;
  logic                       x_move, y_move, emit, last;

  assign pop_o = q_valid_i && (!out_valid_q || !out_stall_i);
  assign emit  = pop_o && (cmd_i.is_start || active_q);

  // e2 = 2*err against -dy and dx
  assign e2     = {err_q, 1'b0};
  assign dx_w   = signed'({(WideBits - lr_pkg::COORD_BITS)'(0), dx_q});
  assign dy_w   = signed'({(WideBits - lr_pkg::COORD_BITS)'(0), dy_q});
  assign x_move = (e2 > -dy_w);
  assign y_move = (e2 < dx_w);

  always_comb begin
    cur_x_d = cur_x_q;
    cur_y_d = cur_y_q;
    tgt_x_d = tgt_x_q;
    tgt_y_d = tgt_y_q;
    dx_d    = dx_q;
    dy_d    = dy_q;
    x_neg_d = x_neg_q;
    y_neg_d = y_neg_q;
    err_d   = err_q;
    err_w   = WideBits'(err_q);
    if (cmd_i.is_start) begin
      cur_x_d = cmd_i.x1;
      cur_y_d = cmd_i.y1;
      tgt_x_d = cmd_i.x2;
      tgt_y_d = cmd_i.y2;
      dx_d    = cmd_i.abs_dx;
      dy_d    = cmd_i.abs_dy;
      x_neg_d = cmd_i.x_neg;
      y_neg_d = cmd_i.y_neg;
      err_d   = lr_pkg::ERR_BITS'({2'b00, cmd_i.abs_dx})
              - lr_pkg::ERR_BITS'({2'b00, cmd_i.abs_dy});
    end else begin
      if (x_move) begin
        err_w   = err_w - dy_w;
        cur_x_d = x_neg_q ? cur_x_q - 1'b1 : cur_x_q + 1'b1;
      end
      if (y_move) begin
        err_w   = err_w + dx_w;
        cur_y_d = y_neg_q ? cur_y_q - 1'b1 : cur_y_q + 1'b1;
      end
      err_d = err_w[lr_pkg::ERR_BITS-1:0];
    end
  end

  assign last = (cur_x_d == tgt_x_d) && (cur_y_d == tgt_y_d);

  always_comb begin
    active_d    = active_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_data_d  = out_data_q;
    if (emit) begin
      active_d               = !last;
      out_valid_d            = 1'b1;
      out_data_d.pixel_x     = cur_x_d;
      out_data_d.pixel_y     = cur_y_d;
      out_data_d.pixel_color = draw_color_i;
      out_data_d.last_pixel  = last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      active_q    <= active_d;
      out_valid_q <= out_valid_d;
    end
  end

  // line datapath, loaded only when a pixel is emitted
  always_ff @(posedge clk_i) begin
    if (emit) begin
      cur_x_q <= cur_x_d;
      cur_y_q <= cur_y_d;
      tgt_x_q <= tgt_x_d;
      tgt_y_q <= tgt_y_d;
      dx_q    <= dx_d;
      dy_q    <= dy_d;
      x_neg_q <= x_neg_d;
      y_neg_q <= y_neg_d;
      err_q   <= err_d;
    end
    out_data_q <= out_data_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

FILE: rtl/core/line_rasterizer_core.sv
`timescale 1ns / 1ps

// Bresenham line engine, all octants. A start transfer (func = 0) loads both
// endpoints and produces the first pixel; each step transfer (func = 1)
// produces the next pixel, and the pixel that reaches the endpoint carries
// last_pixel. A step while no line is in progress produces nothing; a start
// always restarts. Sustained rate is one input transfer and one pixel per
// clock while the output is not stalled, with the error update done
// combinationally in the back end. Each pixel leaves through the output
// register; a two-entry command queue sits between the front decoder and
// the stepper so each side can stall on its own. Every pixel carries
// draw_color (APB register 0, reset 4'hF).
module line_rasterizer_core (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // input channel
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  lr_pkg::in_item_t                    in_data_i,
  // pixel channel
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output lr_pkg::pixel_t                      out_data_o,
  // APB configuration port
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [lr_pkg::APB_ADDR_BITS-1:0]    paddr,
  input  logic [lr_pkg::APB_DATA_BITS-1:0]    pwdata,
  output logic [lr_pkg::APB_DATA_BITS-1:0]    prdata,
  output logic                                pready
);

  logic                          push, pop, q_full, q_valid;
  lr_pkg::cmd_t                  push_cmd, head_cmd;
  logic [lr_pkg::COLOR_BITS-1:0] draw_color_q;
  logic                          reg_hit;

  // --- configuration: paddr[2] selects the register, byte addresses 4 and up ignored
  assign pready  = 1'b1;
  assign reg_hit = (paddr[2] == lr_pkg::REG_DRAW_COLOR);
  assign prdata  = reg_hit ? lr_pkg::APB_DATA_BITS'(draw_color_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      draw_color_q <= lr_pkg::DRAW_COLOR_RESET;
    end else if (psel && penable && pwrite && pready && reg_hit) begin
      draw_color_q <= pwdata[lr_pkg::COLOR_BITS-1:0];
    end
  end

  // --- front: accept and decode
  lr_front u_front (
    .in_valid_i (in_valid_i),
    .in_data_i  (in_data_i),
    .q_full_i   (q_full),
    .in_stall_o (in_stall_o),
    .push_o     (push),
    .cmd_o      (push_cmd)
  );

  // --- decoupling queue
  lr_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_cmd_i (push_cmd),
    .pop_i      (pop),
    .full_o     (q_full),
    .valid_o    (q_valid),
    .head_o     (head_cmd)
  );

  // --- back: stepping and output register
  lr_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .q_valid_i    (q_valid),
    .cmd_i        (head_cmd),
    .draw_color_i (draw_color_q),
    .out_stall_i  (out_stall_i),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_data_o   (out_data_o)
  );

endmodule

FILE: rtl/core/lr_checker.sv
`timescale 1ns / 1ps

`include "line_rasterizer_core_defines.svh"

module lr_checker (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_stall_o,
  input  logic                             out_valid_o,
  input  logic                             out_stall_i,
  input  lr_pkg::pixel_t                   out_data_o,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [lr_pkg::APB_ADDR_BITS-1:0] paddr,
  input  logic [lr_pkg::APB_DATA_BITS-1:0] pwdata,
  input  logic [lr_pkg::APB_DATA_BITS-1:0] prdata,
  input  logic                             pready
);

  // pixel held under stall
  `LR_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o)
  `LR_ASSERT_NEXT(a_out_stable, out_valid_o && out_stall_i, $stable(out_data_o))
  // queue drains one per clock while the sink keeps up, so input never backs up
  `LR_ASSERT_NEXT(a_no_backup, !out_stall_i && !in_stall_o, !in_stall_o)
  // colour register reads back what was written
  `LR_ASSERT_NEXT(a_color_rb, psel && penable && pwrite && pready && !paddr[2],
                  paddr[2] || (prdata[3:0] == $past(pwdata[3:0])))

endmodule

bind line_rasterizer_core lr_checker u_lr_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o),
  .psel        (psel),
  .penable     (penable),
  .pwrite      (pwrite),
  .paddr       (paddr),
  .pwdata      (pwdata),
  .prdata      (prdata),
  .pready      (pready)
);

FILE: tb/tb_line_rasterizer_core.sv
`timescale 1ns / 1ps

// Expected-pixel ledger: mirrors the line stepper and keeps the pixels
// still owed by the block, oldest first.
class pixel_ledger;
  logic [lr_pkg::COORD_BITS-1:0]      cur_x, cur_y, tgt_x, tgt_y;
  logic [lr_pkg::COORD_BITS-1:0]      span_x, span_y;
  logic                               x_back, y_back;
  logic signed [lr_pkg::ERR_BITS-1:0] err_acc;
  logic                               drawing;
  logic [lr_pkg::COLOR_BITS-1:0]      color;
  lr_pkg::pixel_t                     expected_pixels[$];

  function new();
    cur_x = '0; cur_y = '0; tgt_x = '0; tgt_y = '0;
    span_x = '0; span_y = '0;
    x_back = 1'b0; y_back = 1'b0;
    err_acc = '0;
    drawing = 1'b0;
    color = lr_pkg::DRAW_COLOR_RESET;
  endfunction

  function void set_color(logic [lr_pkg::APB_DATA_BITS-1:0] value);
    color = value[lr_pkg::COLOR_BITS-1:0];
  endfunction

  function int pending();
    return expected_pixels.size();
  endfunction

  function void push_pixel();
    lr_pkg::pixel_t p;
    p.pixel_x     = cur_x;
    p.pixel_y     = cur_y;
    p.pixel_color = color;
    p.last_pixel  = (cur_x == tgt_x) && (cur_y == tgt_y);
    drawing = !p.last_pixel;
    expected_pixels.push_back(p);
  endfunction

  // one accepted input transfer
  function void note_command(lr_pkg::in_item_t cmd);
    int e2;
    if (cmd.func == lr_pkg::FUNC_START) begin
      span_x  = (cmd.x_end >= cmd.x_start) ? cmd.x_end - cmd.x_start : cmd.x_start - cmd.x_end;
      span_y  = (cmd.y_end >= cmd.y_start) ? cmd.y_end - cmd.y_start : cmd.y_start - cmd.y_end;
      x_back  = !(cmd.x_start < cmd.x_end);
      y_back  = !(cmd.y_start < cmd.y_end);
      err_acc = $signed({2'b00, span_x}) - $signed({2'b00, span_y});
      cur_x   = cmd.x_start;
      cur_y   = cmd.y_start;
      tgt_x   = cmd.x_end;
      tgt_y   = cmd.y_end;
      push_pixel();
    end else if (drawing) begin
      // both tests use the error before either update
      e2 = 2 * int'(err_acc);
      if (e2 > -int'(span_y)) begin
        err_acc = err_acc - $signed({2'b00, span_y});
        cur_x   = x_back ? cur_x - 1'b1 : cur_x + 1'b1;
      end
      if (e2 < int'(span_x)) begin
        err_acc = err_acc + $signed({2'b00, span_x});
        cur_y   = y_back ? cur_y - 1'b1 : cur_y + 1'b1;
      end
      push_pixel();
    end
  endfunction

  // one accepted pixel; returns 0 and a description on a mismatch
  function bit check_pixel(lr_pkg::pixel_t got, output string why);
    lr_pkg::pixel_t want;
    why = "";
    if (expected_pixels.size() == 0) begin
      why = $sformatf("pixel (%0d,%0d) arrived with none expected", got.pixel_x, got.pixel_y);
      return 1'b0;
    end
    want = expected_pixels.pop_front();
    if (got.pixel_x !== want.pixel_x)
      why = {why, $sformatf(" x %0d/%0d", got.pixel_x, want.pixel_x)};
    if (got.pixel_y !== want.pixel_y)
      why = {why, $sformatf(" y %0d/%0d", got.pixel_y, want.pixel_y)};
    if (got.pixel_color !== want.pixel_color)
      why = {why, $sformatf(" color %0d/%0d", got.pixel_color, want.pixel_color)};
    if (got.last_pixel !== want.last_pixel)
      why = {why, $sformatf(" last %0b/%0b", got.last_pixel, want.last_pixel)};
    if (why != "") begin
      why = {"pixel field mismatch (got/exp):", why};
      return 1'b0;
    end
    return 1'b1;
  endfunction
endclass

module tb_line_rasterizer_core;

  localparam int TOTAL_ITEMS      = 900;
  localparam int LONG_HOLD_CYCLES = 300;  // receiver hold-off for the backpressure phase
  localparam int SETTLE_CYCLES    = 8;
  localparam int TAIL_CYCLES      = 16;
  localparam int WATCHDOG_LIMIT   = 3000; // well over the long hold plus gaps
  localparam int CFG_INTERVAL     = 180;
  localparam int COORD_MAX        = (1 << lr_pkg::COORD_BITS) - 1;

  // register map: index i at byte address 4*i
  localparam logic [lr_pkg::APB_ADDR_BITS-1:0] ADDR_DRAW_COLOR = {lr_pkg::REG_DRAW_COLOR, 2'b00};
  localparam logic [lr_pkg::APB_ADDR_BITS-1:0] ADDR_SPARE      = 3'b100;  // index 1, unmapped

  logic                             clk_i;
  logic                             rst_ni      = 1'b0;
  logic                             in_valid_i  = 1'b0;
  logic                             in_stall_o;
  lr_pkg::in_item_t                 in_data_i   = '0;
  logic                             out_valid_o;
  logic                             out_stall_i = 1'b0;
  lr_pkg::pixel_t                   out_data_o;
  logic                             psel        = 1'b0;
  logic                             penable     = 1'b0;
  logic                             pwrite      = 1'b0;
  logic [lr_pkg::APB_ADDR_BITS-1:0] paddr       = '0;
  logic [lr_pkg::APB_DATA_BITS-1:0] pwdata      = '0;
  logic [lr_pkg::APB_DATA_BITS-1:0] prdata;
  logic                             pready;

  pixel_ledger ledger = new();

  int  errors       = 0;
  int  items_sent   = 0;
  int  starts_seen  = 0;
  int  steps_seen   = 0;
  int  pixels_seen  = 0;
  int  ends_seen    = 0;
  int  color_writes = 0;
  int  quiet_cycles = 0;

  // sender pacing
  bit  steady     = 1'b0;  // no gaps while set
  int  burst_left = 0;

  // set by the stimulus, cleared by the receiver once the hold is over
  bit  long_hold_req = 1'b0;

  line_rasterizer_core uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  task automatic report_mismatch(string msg);
    errors++;
    $display("[%0t] MISMATCH: %s", $time, msg);
  endtask

  // ---------------------------------------------------------------------------
  // Monitor: both channels sampled at the rising edge, i.e. the values the
  // block itself saw. Inputs are noted before outputs are checked.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    string why;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        if (in_data_i.func == lr_pkg::FUNC_START) starts_seen++;
        else steps_seen++;
        ledger.note_command(in_data_i);
      end
      if (out_valid_o && !out_stall_i) begin
        pixels_seen++;
        if (out_data_o.last_pixel) ends_seen++;
        if (!ledger.check_pixel(out_data_o, why)) report_mismatch(why);
      end
    end
  end

  // Watchdog: only counts cycles with no transfer on either channel.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == WATCHDOG_LIMIT) begin
        $display("[%0t] timeout, %0d pixels outstanding", $time, ledger.pending());
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: stall pattern is picked at random for each span (none, light,
  // heavy, periodic). A long hold request takes priority and is timed here.
  // ---------------------------------------------------------------------------
  initial begin : receiver
    int mode;
    int span;
    int phase;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (long_hold_req) begin
        out_stall_i <= 1'b1;
        repeat (LONG_HOLD_CYCLES) @(posedge clk_i);
        long_hold_req = 1'b0;
      end else begin
        mode  = $urandom_range(0, 3);
        span  = $urandom_range(8, 60);
        phase = 0;
        repeat (span) begin
          case (mode)
            0: begin
              out_stall_i <= 1'b0;
            end
            1: begin
              out_stall_i <= ($urandom_range(0, 99) < 25);
            end
            2: begin
              out_stall_i <= ($urandom_range(0, 99) < 75);
            end
            default: begin
              out_stall_i <= (phase % 5) < 2;
            end
          endcase
          phase++;
          @(posedge clk_i);
          if (long_hold_req) break;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sender tasks. Each is entered right after a rising edge and returns at
  // the edge where its transfer happened, or later if pace() adds a gap.
  // ---------------------------------------------------------------------------
  task automatic pace();
    int gap;
    if (steady) return;
    if (burst_left > 0) begin
      burst_left--;
      return;
    end
    burst_left = $urandom_range(1, 24);
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
    if ($urandom_range(0, 15) == 0) gap = 30;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic send_item(lr_pkg::in_item_t item);
    in_valid_i <= 1'b1;
    in_data_i  <= item;
    do @(posedge clk_i); while (in_stall_o);
    items_sent++;
    pace();
  endtask

  task automatic send_start(int x1, int y1, int x2, int y2);
    lr_pkg::in_item_t item;
    item.func    = lr_pkg::FUNC_START;
    item.x_start = x1[lr_pkg::COORD_BITS-1:0];
    item.y_start = y1[lr_pkg::COORD_BITS-1:0];
    item.x_end   = x2[lr_pkg::COORD_BITS-1:0];
    item.y_end   = y2[lr_pkg::COORD_BITS-1:0];
    send_item(item);
  endtask

  // step transfers carry junk coordinates; the block must ignore them
  task automatic send_step();
    lr_pkg::in_item_t item;
    item.func    = lr_pkg::FUNC_STEP;
    item.x_start = lr_pkg::COORD_BITS'($urandom_range(0, COORD_MAX));
    item.y_start = lr_pkg::COORD_BITS'($urandom_range(0, COORD_MAX));
    item.x_end   = lr_pkg::COORD_BITS'($urandom_range(0, COORD_MAX));
    item.y_end   = lr_pkg::COORD_BITS'($urandom_range(0, COORD_MAX));
    send_item(item);
  endtask

  // Stop offering and wait until every owed pixel is out, plus a margin for
  // a step that produced nothing but may still be in the queue.
  task automatic drain();
    in_valid_i <= 1'b0;
    while (ledger.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // APB: setup then access; each task releases psel before it returns.
  // ---------------------------------------------------------------------------
  task automatic apb_write(logic [lr_pkg::APB_ADDR_BITS-1:0] addr,
                           logic [lr_pkg::APB_DATA_BITS-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic apb_read(logic [lr_pkg::APB_ADDR_BITS-1:0] addr,
                          output logic [lr_pkg::APB_DATA_BITS-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= addr;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    data     = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic verify_color();
    logic [lr_pkg::APB_DATA_BITS-1:0] rd;
    apb_read(ADDR_DRAW_COLOR, rd);
    if (rd[lr_pkg::COLOR_BITS-1:0] !== ledger.color)
      report_mismatch($sformatf("draw_color read %0d, expected %0d",
                                rd[lr_pkg::COLOR_BITS-1:0], ledger.color));
  endtask

  // upper data bits are random so the register must mask them off
  task automatic program_color(logic [lr_pkg::COLOR_BITS-1:0] c);
    logic [lr_pkg::APB_DATA_BITS-1:0] data;
    drain();
    data = $urandom();
    data[lr_pkg::COLOR_BITS-1:0] = c;
    apb_write(ADDR_DRAW_COLOR, data);
    ledger.set_color(data);
    color_writes++;
    verify_color();
  endtask

  // ---------------------------------------------------------------------------
  // Random line generation
  // ---------------------------------------------------------------------------
  function automatic int near_coord(int base, int reach);
    int d;
    d = $urandom_range(0, reach);
    if ($urandom_range(0, 1)) d = -d;
    if (base + d < 0 || base + d > COORD_MAX) d = -d;
    return base + d;
  endfunction

  function automatic int edge_or_any();
    case ($urandom_range(0, 9))
      0:       return 0;
      1:       return COORD_MAX;
      default: return $urandom_range(0, COORD_MAX);
    endcase
  endfunction

  // Well-formed line: start plus the steps to its end, sometimes cut short
  // by the next start, sometimes followed by steps with no line active.
  task automatic draw_random_line();
    int x1, y1, x2, y2, reach, dx, dy, n, pick;
    reach = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 80) : $urandom_range(0, 12);
    x1 = edge_or_any();
    y1 = edge_or_any();
    x2 = near_coord(x1, reach);
    y2 = near_coord(y1, reach);
    dx = (x2 > x1) ? x2 - x1 : x1 - x2;
    dy = (y2 > y1) ? y2 - y1 : y1 - y2;
    n  = (dx > dy) ? dx : dy;
    pick = $urandom_range(0, 99);
    if (pick < 15 && n > 0) n = $urandom_range(0, n - 1);
    else if (pick < 30) n = n + $urandom_range(1, 3);
    send_start(x1, y1, x2, y2);
    repeat (n) send_step();
  endtask

  // fully random endpoints, usually a long line cut off after a few pixels
  task automatic draw_wild_line();
    send_start($urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX),
               $urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX));
    repeat ($urandom_range(0, 6)) send_step();
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    logic [lr_pkg::APB_DATA_BITS-1:0] junk;
    int  next_cfg;
    int  pick;
    bit  hold_done;
    bit  pause_done;

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset value of the color register
    verify_color();

    // Directed part, reset color. Step with no line, single-point lines at
    // both corners, then axis-aligned lines in both directions.
    send_step();
    send_start(0, 0, 0, 0);
    send_step();
    send_start(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX);
    send_start(0, 0, 3, 0);
    repeat (4) send_step();  // last one finds no line active
    send_start(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX - 2);
    repeat (2) send_step();

    // lowest color, and a write to an unmapped address that must be dropped
    program_color('0);
    junk = $urandom();
    apb_write(ADDR_SPARE, junk);
    verify_color();

    // diagonal up-left, steep up-right, restart mid-line, corner to corner
    send_start(10, 10, 7, 13);
    repeat (3) send_step();
    send_start(100, 200, 102, 207);
    repeat (2) send_step();
    send_start(0, COORD_MAX, COORD_MAX, 0);
    send_step();
    send_start(5, 5, 9, 6);
    repeat (4) send_step();

    program_color({lr_pkg::COLOR_BITS{1'b1}});

    // Random part
    next_cfg   = items_sent + CFG_INTERVAL;
    hold_done  = 1'b0;
    pause_done = 1'b0;
    while (items_sent < TOTAL_ITEMS) begin
      if (items_sent >= next_cfg) begin
        program_color(lr_pkg::COLOR_BITS'($urandom_range(0, (1 << lr_pkg::COLOR_BITS) - 1)));
        next_cfg += CFG_INTERVAL;
      end

      // Output held off for a long stretch while the sender keeps going, so
      // the command queue fills and the input stalls.
      if (!hold_done && items_sent > 400) begin
        steady        = 1'b1;
        long_hold_req = 1'b1;
        send_start(0, 0, 300, 100);
        repeat (24) send_step();
        steady    = 1'b0;
        hold_done = 1'b1;
      end

      // sender pauses until the block has caught up completely
      if (!pause_done && items_sent > 600) begin
        drain();
        pause_done = 1'b1;
      end

      steady = ($urandom_range(0, 4) == 0);
      pick   = $urandom_range(0, 99);
      if (pick < 80) draw_random_line();
      else if (pick < 90) send_step();
      else draw_wild_line();
    end
    steady = 1'b0;

    // let everything owed come out, then a tail for stray pixels
    in_valid_i <= 1'b0;
    while (ledger.pending() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("Sent %0d starts and %0d steps; checked %0d pixels, %0d of them line ends.",
             starts_seen, steps_seen, pixels_seen, ends_seen);
    $display("Color register written %0d times incl. 0 and 15; one long output hold, one drain.",
             color_writes);
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

FILE: sim.f
+incdir+rtl/core
rtl/core/lr_pkg.sv
rtl/core/lr_front.sv
rtl/core/lr_queue.sv
rtl/core/lr_back.sv
rtl/core/line_rasterizer_core.sv
rtl/core/lr_checker.sv
tb/tb_line_rasterizer_core.sv
